// ===== hdl/bcat_pkg.sv =====
// Shared constants and types for the block chain allocation table.
// No dependencies; imported by every other file of the block.
`timescale 1ns / 1ps
`default_nettype none

package bcat_pkg;

	localparam int NUM_BLOCKS = 128;
	localparam int IDX_W      = $clog2(NUM_BLOCKS);
	localparam int BLK_W      = 7;   // current_block / result_block field width

	// operation codes (func)
	localparam logic [1:0] FN_START  = 2'd0;
	localparam logic [1:0] FN_EXTEND = 2'd1;
	localparam logic [1:0] FN_FOLLOW = 2'd2;
	localparam logic [1:0] FN_FREE   = 2'd3;

	// status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_FREE = 2'd2;

	// sequencer -> table store
	typedef struct packed {
		logic             link_rd;   // registered read of link_mem[rd_addr]
		logic [IDX_W-1:0] rd_addr;
		logic             link_wr;
		logic [IDX_W-1:0] wr_addr;
		logic [IDX_W-1:0] wr_link;
		logic             vld_set;
		logic             vld_clr;
		logic [IDX_W-1:0] upd_addr;  // valid bit to set or clear
		logic [IDX_W-1:0] chk_addr;  // valid bit looked up this cycle
	} store_req_t;

	typedef struct packed {
		logic [1:0]       status;
		logic             chain_end;
		logic [BLK_W-1:0] blk;
	} result_t;

endpackage

`default_nettype wire

// ===== hdl/bcat_store.sv =====
// Allocation table store: valid flops per block plus the link memory.
// Depends on bcat_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bcat_store (
	input  wire                     clk,
	input  wire                     arst_n,
	input  bcat_pkg::store_req_t    req,
	output logic [bcat_pkg::IDX_W-1:0] rd_link,
	output logic                    chk_valid
);
	import bcat_pkg::*;

	logic [NUM_BLOCKS-1:0] valid_q;
	logic [IDX_W-1:0]      link_mem [NUM_BLOCKS];

	// block 0 holds the directory chain after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= NUM_BLOCKS'(1);
		end else if (req.vld_set) begin
			valid_q[req.upd_addr] <= 1'b1;
		end else if (req.vld_clr) begin
			valid_q[req.upd_addr] <= 1'b0;
		end
	end

	// links are only read for entries in use, which were written at allocation
	// (block 0 by the sequencer's init cycle right after reset)
	always_ff @(posedge clk) begin
		if (req.link_wr) begin
			link_mem[req.wr_addr] <= req.wr_link;
		end
		if (req.link_rd) begin
			rd_link <= link_mem[req.rd_addr];
		end
	end

	assign chk_valid = valid_q[req.chk_addr];

endmodule

`default_nettype wire

// ===== hdl/bcat_ctrl.sv =====
// Operation sequencer: lowest-free scan, linking, link follow and chain walk.
// Depends on bcat_pkg; drives bcat_store through a store_req_t.
`timescale 1ns / 1ps
`default_nettype none

module bcat_ctrl (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        start,
	input  wire  [1:0]                 func_in,
	input  wire  [bcat_pkg::BLK_W-1:0] blk_in,
	output logic                       idle,
	input  wire                        slot_free,
	output logic                       res_load,
	output bcat_pkg::result_t          res,
	output bcat_pkg::store_req_t       req,
	input  wire  [bcat_pkg::IDX_W-1:0] rd_link,
	input  wire                        chk_valid
);
	import bcat_pkg::*;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_CHECK  = 4'd1;
	localparam logic [3:0] S_SCAN   = 4'd2;
	localparam logic [3:0] S_ALLOC  = 4'd3;
	localparam logic [3:0] S_LINK   = 4'd4;
	localparam logic [3:0] S_FOLLOW = 4'd5;
	localparam logic [3:0] S_WALK   = 4'd6;
	localparam logic [3:0] S_DONE   = 4'd7;
	localparam logic [3:0] S_INIT   = 4'd8;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BLOCKS - 1);

	logic [3:0]       state_q, state_d;
	logic [1:0]       func_q;
	logic [BLK_W-1:0] blk_q;
	logic [IDX_W-1:0] idx_q, idx_d;   // scan index, new block, or walk position
	logic [IDX_W-1:0] cnt_q, cnt_d;   // walk step count
	result_t          res_q, res_d;
	logic [IDX_W-1:0] blk_idx;
	logic             blk_ok;

	assign blk_idx = IDX_W'(blk_q);
	assign blk_ok  = (32'(blk_q) < NUM_BLOCKS);

	always_comb begin
		state_d  = state_q;
		idx_d    = idx_q;
		cnt_d    = cnt_q;
		res_d    = res_q;
		req      = '0;
		res_load = 1'b0;
		unique case (state_q)
			S_INIT: begin
				// directory block links to itself
				req.link_wr = 1'b1;
				req.wr_addr = '0;
				req.wr_link = '0;
				state_d     = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					res_d   = '0;
					idx_d   = '0;
					state_d = (func_in == FN_START) ? S_SCAN : S_CHECK;
				end
			end
			S_CHECK: begin
				req.chk_addr = blk_idx;
				if (!(blk_ok && chk_valid)) begin
					res_d.status = ST_FREE;
					state_d      = S_DONE;
				end else if (func_q == FN_EXTEND) begin
					state_d = S_SCAN;
				end else begin
					req.link_rd = 1'b1;
					req.rd_addr = blk_idx;
					idx_d       = blk_idx;
					cnt_d       = '0;
					state_d     = (func_q == FN_FOLLOW) ? S_FOLLOW : S_WALK;
				end
			end
			S_SCAN: begin
				req.chk_addr = idx_q;
				if (!chk_valid) begin
					state_d = S_ALLOC;
				end else if (idx_q == LAST_IDX) begin
					res_d.status = ST_FULL;
					state_d      = S_DONE;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			S_ALLOC: begin
				req.link_wr  = 1'b1;
				req.wr_addr  = idx_q;
				req.wr_link  = idx_q;
				req.vld_set  = 1'b1;
				req.upd_addr = idx_q;
				res_d.blk    = BLK_W'(idx_q);
				state_d      = (func_q == FN_EXTEND) ? S_LINK : S_DONE;
			end
			S_LINK: begin
				req.link_wr = 1'b1;
				req.wr_addr = blk_idx;
				req.wr_link = idx_q;
				state_d     = S_DONE;
			end
			S_FOLLOW: begin
				res_d.blk       = BLK_W'(rd_link);
				res_d.chain_end = (rd_link == blk_idx);
				state_d         = S_DONE;
			end
			S_WALK: begin
				// free the current block; go on while the link leads to another used block and the step bound is not reached
				req.vld_clr  = 1'b1;
				req.upd_addr = idx_q;
				req.chk_addr = rd_link;
				if (rd_link == idx_q || !chk_valid || cnt_q == LAST_IDX) begin
					state_d = S_DONE;
				end else begin
					req.link_rd = 1'b1;
					req.rd_addr = rd_link;
					idx_d       = rd_link;
					cnt_d       = cnt_q + 1'b1;
				end
			end
			S_DONE: begin
				if (slot_free) begin
					res_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (start && state_q == S_IDLE) begin
			func_q <= func_in;
			blk_q  <= blk_in;
		end
		idx_q <= idx_d;
		cnt_q <= cnt_d;
		res_q <= res_d;
	end

	assign idle = (state_q == S_IDLE);
	assign res  = res_q;

endmodule

`default_nettype wire

// ===== hdl/block_chain_allocation_table.sv =====
// Top level of the block chain allocation table: stream ports and result register.
// Depends on bcat_pkg, bcat_store and bcat_ctrl.
//
//   channel  dir  tdata                            tuser
//   s_*      in   [6:0] current_block              [1:0] func
//   m_*      out  [6:0] result_block, [7] chain_end [1:0] status
//
// One operation at a time; s_tready is high only while the sequencer is idle.
// Start and extend are set by the lowest-free scan, which looks at one valid bit
// per cycle; free walks one chain entry per cycle through the link memory port.
// A finished result waits in the output register; the sequencer stalls only
// when a second result is ready before the first is taken.
// Reset leaves every block free except block 0, a one-block chain; the first
// cycle after reset writes block 0's link, with s_tready low.
`timescale 1ns / 1ps
`default_nettype none

module block_chain_allocation_table (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_tvalid,
	output logic       s_tready,
	input  wire  [7:0] s_tdata,   // [6:0] current_block, [7] zero fill
	input  wire  [1:0] s_tuser,   // [1:0] func
	output logic       m_tvalid,
	input  wire        m_tready,
	output logic [7:0] m_tdata,   // [6:0] result_block, [7] chain_end
	output logic [1:0] m_tuser    // [1:0] status
);
	import bcat_pkg::*;

	store_req_t       req;
	result_t          res;
	logic [IDX_W-1:0] rd_link;
	logic             chk_valid;
	logic             idle;
	logic             res_load;
	logic             slot_free;
	logic             m_tvalid_q;
	result_t          out_q;

	assign slot_free = !m_tvalid_q || m_tready;

	bcat_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (s_tvalid),
		.func_in   (s_tuser),
		.blk_in    (s_tdata[BLK_W-1:0]),
		.idle      (idle),
		.slot_free (slot_free),
		.res_load  (res_load),
		.res       (res),
		.req       (req),
		.rd_link   (rd_link),
		.chk_valid (chk_valid)
	);

	bcat_store u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rd_link   (rd_link),
		.chk_valid (chk_valid)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			out_q <= res;
		end
	end

	assign s_tready = idle;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {out_q.chain_end, out_q.blk};
	assign m_tuser  = out_q.status;

endmodule

`default_nettype wire
